### rtl/core/cup_pkg.sv
// Shared types and constants for the canonical UTF-8 path checker.
// Used by the channel interfaces, the path tracker and the top level.
package cup_pkg;

   localparam logic [7:0] BYTE_NUL       = 8'h00;
   localparam logic [7:0] BYTE_ASCII_MAX = 8'h7F;
   localparam logic [7:0] BYTE_DOT       = 8'h2E;
   localparam logic [7:0] BYTE_SLASH     = 8'h2F;
   localparam logic [7:0] BYTE_BACKSLASH = 8'h5C;
   localparam logic [7:0] LEAD2_LO       = 8'hC2;
   localparam logic [7:0] LEAD2_HI       = 8'hDF;
   localparam logic [7:0] LEAD3_LO       = 8'hE0;
   localparam logic [7:0] LEAD3_HI       = 8'hEF;
   localparam logic [7:0] LEAD3_SURR     = 8'hED;
   localparam logic [7:0] LEAD4_LO       = 8'hF0;
   localparam logic [7:0] LEAD4_HI       = 8'hF4;
   localparam logic [7:0] CONT_LO        = 8'h80;
   localparam logic [7:0] CONT_HI        = 8'hBF;
   localparam logic [7:0] CONT_E0_LO     = 8'hA0;
   localparam logic [7:0] CONT_ED_HI     = 8'h9F;
   localparam logic [7:0] CONT_F0_LO     = 8'h90;
   localparam logic [7:0] CONT_F4_HI     = 8'h8F;

   typedef enum logic [3:0] {
      ERR_OK        = 4'd0,
      ERR_SHORT     = 4'd1,
      ERR_NO_LEAD   = 4'd2,
      ERR_TRAIL     = 4'd3,
      ERR_BACKSLASH = 4'd4,
      ERR_EMPTY     = 4'd5,
      ERR_DOT       = 4'd6,
      ERR_NUL       = 4'd7,
      ERR_LEAD      = 4'd8,
      ERR_SEQ       = 4'd9
   } err_type;

   typedef enum logic [2:0] {
      RNG_GEN = 3'd0,
      RNG_E0  = 3'd1,
      RNG_ED  = 3'd2,
      RNG_F0  = 3'd3,
      RNG_F4  = 3'd4
   } rng_type;

   typedef struct packed {
      logic [1:0] bytes_seen;
      logic       first_slash;
      logic [1:0] comp_len;
      logic       all_dots;
      logic [1:0] cont_left;
      rng_type    rng;
      err_type    sfault;
      err_type    efault;
   } path_state_type;

   localparam path_state_type PATH_RESET = '{
      bytes_seen:  2'd0,
      first_slash: 1'b0,
      comp_len:    2'd0,
      all_dots:    1'b1,
      cont_left:   2'd0,
      rng:         RNG_GEN,
      sfault:      ERR_OK,
      efault:      ERR_OK
   };

endpackage

### rtl/core/cup_ifs.sv
// Valid/ready channel interfaces for the canonical UTF-8 path checker.
// Depends on cup_pkg for the error code type.
interface cup_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] path_byte;
   logic       last_byte;
   modport source (output valid, output path_byte, output last_byte, input ready);
   modport sink (input valid, input path_byte, input last_byte, output ready);
endinterface

interface cup_rsp_if;
   logic             valid;
   logic             ready;
   logic             path_ok;
   cup_pkg::err_type error_code;
   modport source (output valid, output path_ok, output error_code, input ready);
   modport sink (input valid, input path_ok, input error_code, output ready);
endinterface

interface cup_csr_if;
   logic valid;
   logic ready;
   logic check_path_rules;
   modport source (output valid, output check_path_rules, input ready);
   modport sink (input valid, input check_path_rules, output ready);
endinterface

### rtl/core/cup_track.sv
// Per-path state and verdict logic of the canonical UTF-8 path checker.
// Depends on cup_pkg; instantiated by canonical_utf8_path_checker.
module cup_track (
   input  logic             clock,
   input  logic             reset,
   input  logic             advance,
   input  logic             path_mode,
   input  logic [7:0]       in_byte,
   input  logic             in_last,
   output cup_pkg::err_type verdict
);

   cup_pkg::path_state_type path_ff;
   cup_pkg::path_state_type path_in;
   cup_pkg::path_state_type path_nxt;

   always_comb begin
      cup_pkg::err_type scand;
      cup_pkg::err_type ecand;
      cup_pkg::err_type ccand;
      cup_pkg::err_type sfin;
      cup_pkg::err_type efin;
      logic [7:0]       lo;
      logic [7:0]       hi;
      path_nxt = path_ff;
      scand    = cup_pkg::ERR_OK;
      ecand    = cup_pkg::ERR_OK;
      ccand    = cup_pkg::ERR_OK;
      lo       = cup_pkg::CONT_LO;
      hi       = cup_pkg::CONT_HI;

      if (path_ff.bytes_seen == 2'd0) begin
         path_nxt.first_slash = (in_byte == cup_pkg::BYTE_SLASH);
      end else if (in_byte == cup_pkg::BYTE_SLASH) begin
         if (path_ff.comp_len == 2'd0) begin
            scand = cup_pkg::ERR_EMPTY;
         end else if (path_ff.all_dots && path_ff.comp_len != 2'd3) begin
            scand = cup_pkg::ERR_DOT;
         end
         path_nxt.comp_len = 2'd0;
         path_nxt.all_dots = 1'b1;
      end else begin
         if (in_byte == cup_pkg::BYTE_BACKSLASH) begin
            scand = cup_pkg::ERR_BACKSLASH;
         end
         if (path_ff.comp_len != 2'd3) begin
            path_nxt.comp_len = path_ff.comp_len + 2'd1;
         end
         if (in_byte != cup_pkg::BYTE_DOT) begin
            path_nxt.all_dots = 1'b0;
         end
      end
      if (path_ff.sfault == cup_pkg::ERR_OK) begin
         path_nxt.sfault = scand;
      end
      if (path_ff.bytes_seen != 2'd2) begin
         path_nxt.bytes_seen = path_ff.bytes_seen + 2'd1;
      end

      if (path_ff.cont_left != 2'd0) begin
         case (path_ff.rng)
            cup_pkg::RNG_E0: lo = cup_pkg::CONT_E0_LO;
            cup_pkg::RNG_ED: hi = cup_pkg::CONT_ED_HI;
            cup_pkg::RNG_F0: lo = cup_pkg::CONT_F0_LO;
            cup_pkg::RNG_F4: hi = cup_pkg::CONT_F4_HI;
            default: ;
         endcase
         if (in_byte < lo || in_byte > hi) begin
            ecand = cup_pkg::ERR_SEQ;
         end
         path_nxt.cont_left = path_ff.cont_left - 2'd1;
         path_nxt.rng       = cup_pkg::RNG_GEN;
      end else begin
         case (in_byte) inside
            cup_pkg::BYTE_NUL: ecand = cup_pkg::ERR_NUL;
            [8'h01:cup_pkg::BYTE_ASCII_MAX]: ;
            [cup_pkg::LEAD2_LO:cup_pkg::LEAD2_HI]: begin
               path_nxt.cont_left = 2'd1;
               path_nxt.rng       = cup_pkg::RNG_GEN;
            end
            [cup_pkg::LEAD3_LO:cup_pkg::LEAD3_HI]: begin
               path_nxt.cont_left = 2'd2;
               if (in_byte == cup_pkg::LEAD3_LO) begin
                  path_nxt.rng = cup_pkg::RNG_E0;
               end else if (in_byte == cup_pkg::LEAD3_SURR) begin
                  path_nxt.rng = cup_pkg::RNG_ED;
               end else begin
                  path_nxt.rng = cup_pkg::RNG_GEN;
               end
            end
            [cup_pkg::LEAD4_LO:cup_pkg::LEAD4_HI]: begin
               path_nxt.cont_left = 2'd3;
               if (in_byte == cup_pkg::LEAD4_LO) begin
                  path_nxt.rng = cup_pkg::RNG_F0;
               end else if (in_byte == cup_pkg::LEAD4_HI) begin
                  path_nxt.rng = cup_pkg::RNG_F4;
               end else begin
                  path_nxt.rng = cup_pkg::RNG_GEN;
               end
            end
            default: ecand = cup_pkg::ERR_LEAD;
         endcase
      end
      if (path_ff.efault == cup_pkg::ERR_OK) begin
         path_nxt.efault = ecand;
      end

      efin = path_nxt.efault;
      if (path_nxt.cont_left != 2'd0 && efin == cup_pkg::ERR_OK) begin
         efin = cup_pkg::ERR_SEQ;
      end
      if (path_nxt.comp_len == 2'd0) begin
         ccand = cup_pkg::ERR_EMPTY;
      end else if (path_nxt.all_dots && path_nxt.comp_len != 2'd3) begin
         ccand = cup_pkg::ERR_DOT;
      end
      sfin = (path_nxt.sfault != cup_pkg::ERR_OK) ? path_nxt.sfault : ccand;

      if (!path_mode) begin
         verdict = efin;
      end else if (path_nxt.bytes_seen != 2'd2) begin
         verdict = cup_pkg::ERR_SHORT;
      end else if (!path_nxt.first_slash) begin
         verdict = cup_pkg::ERR_NO_LEAD;
      end else if (in_byte == cup_pkg::BYTE_SLASH) begin
         verdict = cup_pkg::ERR_TRAIL;
      end else if (sfin != cup_pkg::ERR_OK) begin
         verdict = sfin;
      end else begin
         verdict = efin;
      end
   end

   always_comb begin
      path_in = path_ff;
      if (advance) begin
         path_in = in_last ? cup_pkg::PATH_RESET : path_nxt;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         path_ff <= cup_pkg::PATH_RESET;
      end else begin
         path_ff <= path_in;
      end
   end

`ifndef SYNTH
   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      advance && in_last |=> path_ff.bytes_seen == 2'd0 && path_ff.cont_left == 2'd0
         && path_ff.sfault == cup_pkg::ERR_OK && path_ff.efault == cup_pkg::ERR_OK)
      else $error("path state not cleared after verdict");
   a_range_idle: assert property (@(posedge clock) disable iff (reset)
      path_ff.cont_left == 2'd0 |-> path_ff.rng == cup_pkg::RNG_GEN)
      else $error("narrowed range held outside a sequence");
   a_fault_classes: assert property (@(posedge clock) disable iff (reset)
      (path_ff.sfault == cup_pkg::ERR_OK || path_ff.sfault == cup_pkg::ERR_BACKSLASH
         || path_ff.sfault == cup_pkg::ERR_EMPTY || path_ff.sfault == cup_pkg::ERR_DOT)
      && (path_ff.efault == cup_pkg::ERR_OK || path_ff.efault == cup_pkg::ERR_NUL
         || path_ff.efault == cup_pkg::ERR_LEAD || path_ff.efault == cup_pkg::ERR_SEQ))
      else $error("fault recorded in the wrong class");
`endif

endmodule

### rtl/core/canonical_utf8_path_checker.sv
// Top level of the canonical UTF-8 path checker: input stage, tracker and result register.
// Depends on cup_pkg, the channel interfaces in cup_ifs and cup_track.
//
// A path enters on req_bus one byte per transaction, its final byte marked by last_byte.
// Each marked byte yields one transaction on rsp_bus carrying path_ok and error_code;
// unmarked bytes yield nothing. csr_bus writes check_path_rules (1 = structure and UTF-8,
// 0 = UTF-8 only) and is always ready; the user must write it only while the block is idle,
// which the block itself does not enforce. A byte is registered in the input stage at
// acceptance and judged when it leaves that stage; for a marked byte the verdict is then
// loaded into the result register, which offers it on rsp_bus. One byte is taken every
// cycle, by one tracker update per byte, unless a marked byte waits in the input stage.
// When the receiver stalls, the waiting result holds and the input stage keeps accepting
// unmarked bytes; a marked byte waits in the input stage until the result register frees.
// Reset is synchronous and active high: it empties both stages, clears the path state and
// sets check_path_rules to 1.
module canonical_utf8_path_checker (
   input logic      clock,
   input logic      reset,
   cup_req_if.sink  req_bus,
   cup_rsp_if.source rsp_bus,
   cup_csr_if.sink  csr_bus
);

   logic             mode_ff;
   logic             mode_in;
   logic             stg_valid_ff;
   logic             stg_valid_in;
   logic [7:0]       stg_byte_ff;
   logic             stg_last_ff;
   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   logic             rsp_ok_ff;
   cup_pkg::err_type rsp_code_ff;
   cup_pkg::err_type verdict;
   logic             out_free;
   logic             advance;
   logic             out_load;
   logic             req_take;

   assign out_free = !rsp_valid_ff || rsp_bus.ready;
   assign advance  = stg_valid_ff && (!stg_last_ff || out_free);
   assign out_load = advance && stg_last_ff;
   assign req_bus.ready = !stg_valid_ff || advance;
   assign req_take = req_bus.valid && req_bus.ready;
   assign csr_bus.ready = 1'b1;

   assign mode_in      = (csr_bus.valid && csr_bus.ready) ? csr_bus.check_path_rules : mode_ff;
   assign stg_valid_in = req_take || (stg_valid_ff && !advance);
   assign rsp_valid_in = out_load || (rsp_valid_ff && !rsp_bus.ready);

   cup_track u_track (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .path_mode (mode_ff),
      .in_byte   (stg_byte_ff),
      .in_last   (stg_last_ff),
      .verdict   (verdict)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= 1'b1;
         stg_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mode_ff      <= mode_in;
         stg_valid_ff <= stg_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         stg_byte_ff <= req_bus.path_byte;
         stg_last_ff <= req_bus.last_byte;
      end
      if (out_load) begin
         rsp_code_ff <= verdict;
         rsp_ok_ff   <= (verdict == cup_pkg::ERR_OK);
      end
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.path_ok    = rsp_ok_ff;
   assign rsp_bus.error_code = rsp_code_ff;

`ifndef SYNTH
   a_ok_matches_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_ok_ff == (rsp_code_ff == cup_pkg::ERR_OK))
      else $error("path_ok disagrees with error_code");
   a_utf8_mode_codes: assert property (@(posedge clock) disable iff (reset)
      out_load && !mode_ff |=> rsp_valid_ff && (rsp_code_ff == cup_pkg::ERR_OK
         || rsp_code_ff == cup_pkg::ERR_NUL || rsp_code_ff == cup_pkg::ERR_LEAD
         || rsp_code_ff == cup_pkg::ERR_SEQ))
      else $error("structural verdict given in UTF-8 mode");
   a_unmarked_flows: assert property (@(posedge clock) disable iff (reset)
      stg_valid_ff && !stg_last_ff |-> advance)
      else $error("unmarked byte stalled in the input stage");
`endif

endmodule

### tb/canonical_utf8_path_checker_tb.sv
// Testbench for canonical_utf8_path_checker: directed and random paths in both checking modes.
// Depends on cup_pkg and the channel interfaces in cup_ifs; every verdict is checked against
// an in-bench prediction of the path and UTF-8 rules.
module canonical_utf8_path_checker_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STALL_LIMIT = 2000;

   typedef struct {
      logic             ok;
      cup_pkg::err_type code;
   } verdict_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   cup_req_if req_bus ();
   cup_rsp_if rsp_bus ();
   cup_csr_if csr_bus ();

   canonical_utf8_path_checker uut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   always #10 clock = ~clock;

   verdict_type expected_verdicts[$];
   logic [7:0]  path_buf[$];
   int          mismatches = 0;
   int          verdicts_checked = 0;
   int          bytes_sent = 0;
   int          quiet_cycles = 0;
   bit          steady_flow = 1'b0;

   logic             path_rules_on;
   logic [1:0]       seen;
   logic             lead_slash;
   logic [1:0]       seg_len;
   logic             seg_all_dots;
   logic [1:0]       cont_left;
   cup_pkg::rng_type next_rng;
   cup_pkg::err_type struct_err;
   cup_pkg::err_type enc_err;

   function automatic void clear_path_state();
      seen = 2'd0;
      lead_slash = 1'b0;
      seg_len = 2'd0;
      seg_all_dots = 1'b1;
      cont_left = 2'd0;
      next_rng = cup_pkg::RNG_GEN;
      struct_err = cup_pkg::ERR_OK;
      enc_err = cup_pkg::ERR_OK;
   endfunction

   function automatic void note_struct(input cup_pkg::err_type code);
      if (struct_err == cup_pkg::ERR_OK) struct_err = code;
   endfunction

   function automatic void note_enc(input cup_pkg::err_type code);
      if (enc_err == cup_pkg::ERR_OK) enc_err = code;
   endfunction

   function automatic void close_segment();
      if (seg_len == 2'd0) begin
         note_struct(cup_pkg::ERR_EMPTY);
      end else if (seg_all_dots && seg_len <= 2'd2) begin
         note_struct(cup_pkg::ERR_DOT);
      end
      seg_len = 2'd0;
      seg_all_dots = 1'b1;
   endfunction

   function automatic void track_segment(input logic [7:0] b);
      if (b == cup_pkg::BYTE_SLASH) begin
         close_segment();
         return;
      end
      if (b == cup_pkg::BYTE_BACKSLASH) note_struct(cup_pkg::ERR_BACKSLASH);
      if (seg_len < 2'd3) seg_len = seg_len + 2'd1;
      if (b != cup_pkg::BYTE_DOT) seg_all_dots = 1'b0;
   endfunction

   function automatic void track_utf8(input logic [7:0] b);
      logic [7:0] lo;
      logic [7:0] hi;
      lo = cup_pkg::CONT_LO;
      hi = cup_pkg::CONT_HI;
      if (cont_left != 2'd0) begin
         case (next_rng)
            cup_pkg::RNG_E0: lo = cup_pkg::CONT_E0_LO;
            cup_pkg::RNG_ED: hi = cup_pkg::CONT_ED_HI;
            cup_pkg::RNG_F0: lo = cup_pkg::CONT_F0_LO;
            cup_pkg::RNG_F4: hi = cup_pkg::CONT_F4_HI;
            default: ;
         endcase
         if (b < lo || b > hi) note_enc(cup_pkg::ERR_SEQ);
         cont_left = cont_left - 2'd1;
         next_rng = cup_pkg::RNG_GEN;
      end else if (b == cup_pkg::BYTE_NUL) begin
         note_enc(cup_pkg::ERR_NUL);
      end else if (b <= cup_pkg::BYTE_ASCII_MAX) begin
      end else if (b >= cup_pkg::LEAD2_LO && b <= cup_pkg::LEAD2_HI) begin
         cont_left = 2'd1;
         next_rng = cup_pkg::RNG_GEN;
      end else if (b >= cup_pkg::LEAD3_LO && b <= cup_pkg::LEAD3_HI) begin
         cont_left = 2'd2;
         next_rng = (b == cup_pkg::LEAD3_LO) ? cup_pkg::RNG_E0 :
                    (b == cup_pkg::LEAD3_SURR) ? cup_pkg::RNG_ED : cup_pkg::RNG_GEN;
      end else if (b >= cup_pkg::LEAD4_LO && b <= cup_pkg::LEAD4_HI) begin
         cont_left = 2'd3;
         next_rng = (b == cup_pkg::LEAD4_LO) ? cup_pkg::RNG_F0 :
                    (b == cup_pkg::LEAD4_HI) ? cup_pkg::RNG_F4 : cup_pkg::RNG_GEN;
      end else begin
         note_enc(cup_pkg::ERR_LEAD);
      end
   endfunction

   function automatic void absorb_byte(input logic [7:0] b, input logic last);
      cup_pkg::err_type code;
      verdict_type      v;
      bytes_sent++;
      if (seen == 2'd0) begin
         lead_slash = (b == cup_pkg::BYTE_SLASH);
      end else begin
         track_segment(b);
      end
      if (seen < 2'd2) seen = seen + 2'd1;
      track_utf8(b);
      if (!last) return;
      if (cont_left != 2'd0) note_enc(cup_pkg::ERR_SEQ);
      if (path_rules_on) begin
         if (seen < 2'd2) begin
            code = cup_pkg::ERR_SHORT;
         end else if (!lead_slash) begin
            code = cup_pkg::ERR_NO_LEAD;
         end else if (b == cup_pkg::BYTE_SLASH) begin
            code = cup_pkg::ERR_TRAIL;
         end else begin
            close_segment();
            code = (struct_err != cup_pkg::ERR_OK) ? struct_err : enc_err;
         end
      end else begin
         code = enc_err;
      end
      v.ok = (code == cup_pkg::ERR_OK);
      v.code = code;
      expected_verdicts.push_back(v);
      clear_path_state();
   endfunction

   function automatic int pick_gap();
      if (steady_flow) return 0;
      if ($urandom_range(99) < 22) return $urandom_range(1, 3);
      return 0;
   endfunction

   task automatic send_byte(input logic [7:0] b, input logic last);
      int gap;
      gap = pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.path_byte <= b;
      req_bus.last_byte <= last;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      absorb_byte(b, last);
   endtask

   task automatic send_buffered_path();
      for (int i = 0; i < path_buf.size(); i++) begin
         send_byte(path_buf[i], i == path_buf.size() - 1);
      end
   endtask

   task automatic drain_verdicts();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (expected_verdicts.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_path_rules(input logic value);
      drain_verdicts();
      @(negedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.check_path_rules <= value;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      path_rules_on = value;
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   function automatic logic [7:0] any_cont();
      return 8'($urandom_range(cup_pkg::CONT_LO, cup_pkg::CONT_HI));
   endfunction

   function automatic void add_char();
      int kind;
      kind = $urandom_range(0, 9);
      case (kind)
         0, 1, 2: path_buf.push_back(8'(32'h61 + $urandom_range(0, 25)));
         3: path_buf.push_back(8'($urandom_range(1, 127)));
         4: begin
            path_buf.push_back(8'($urandom_range(cup_pkg::LEAD2_LO, cup_pkg::LEAD2_HI)));
            path_buf.push_back(any_cont());
         end
         5: begin
            path_buf.push_back(cup_pkg::LEAD3_LO);
            path_buf.push_back(8'($urandom_range(cup_pkg::CONT_E0_LO, cup_pkg::CONT_HI)));
            path_buf.push_back(any_cont());
         end
         6: begin
            path_buf.push_back(cup_pkg::LEAD3_SURR);
            path_buf.push_back(8'($urandom_range(cup_pkg::CONT_LO, cup_pkg::CONT_ED_HI)));
            path_buf.push_back(any_cont());
         end
         7: begin
            if ($urandom_range(0, 1)) begin
               path_buf.push_back(8'($urandom_range(8'hE1, 8'hEC)));
            end else begin
               path_buf.push_back(8'($urandom_range(8'hEE, cup_pkg::LEAD3_HI)));
            end
            path_buf.push_back(any_cont());
            path_buf.push_back(any_cont());
         end
         8: begin
            path_buf.push_back(cup_pkg::LEAD4_LO);
            path_buf.push_back(8'($urandom_range(cup_pkg::CONT_F0_LO, cup_pkg::CONT_HI)));
            path_buf.push_back(any_cont());
            path_buf.push_back(any_cont());
         end
         default: begin
            if ($urandom_range(0, 1)) begin
               path_buf.push_back(cup_pkg::LEAD4_HI);
               path_buf.push_back(8'($urandom_range(cup_pkg::CONT_LO, cup_pkg::CONT_F4_HI)));
            end else begin
               path_buf.push_back(8'($urandom_range(8'hF1, 8'hF3)));
               path_buf.push_back(any_cont());
            end
            path_buf.push_back(any_cont());
            path_buf.push_back(any_cont());
         end
      endcase
   endfunction

   function automatic void build_random_path();
      int n;
      int segs;
      int pick;
      int pos;
      path_buf.delete();
      if ($urandom_range(99) < 25) begin
         n = $urandom_range(1, 5);
         repeat (n) path_buf.push_back(8'($urandom_range(0, 255)));
         return;
      end
      path_buf.push_back(cup_pkg::BYTE_SLASH);
      segs = $urandom_range(1, 3);
      for (int i = 0; i < segs; i++) begin
         if (i > 0) path_buf.push_back(cup_pkg::BYTE_SLASH);
         pick = $urandom_range(99);
         if (pick < 5) begin
         end else if (pick < 10) begin
            path_buf.push_back(cup_pkg::BYTE_DOT);
         end else if (pick < 15) begin
            path_buf.push_back(cup_pkg::BYTE_DOT);
            path_buf.push_back(cup_pkg::BYTE_DOT);
         end else begin
            n = $urandom_range(1, 3);
            repeat (n) add_char();
         end
      end
      if ($urandom_range(99) < 5) path_buf.push_back(cup_pkg::BYTE_SLASH);
      if ($urandom_range(99) < 10) begin
         pos = $urandom_range(0, path_buf.size() - 1);
         path_buf[pos] = 8'($urandom_range(0, 255));
      end
      if (path_buf.size() > 1 && $urandom_range(99) < 5) void'(path_buf.pop_back());
   endfunction

   task automatic test_path_rule_errors();
      set_path_rules(1'b1);
      path_buf = '{cup_pkg::BYTE_SLASH, 8'h61};
      send_buffered_path();
      path_buf = '{cup_pkg::BYTE_SLASH};
      send_buffered_path();
      path_buf = '{8'h61, 8'h62};
      send_buffered_path();
      path_buf = '{cup_pkg::BYTE_SLASH, 8'h61, cup_pkg::BYTE_SLASH};
      send_buffered_path();
      path_buf = '{cup_pkg::BYTE_SLASH, cup_pkg::BYTE_BACKSLASH};
      send_buffered_path();
      path_buf = '{cup_pkg::BYTE_SLASH, cup_pkg::BYTE_SLASH, 8'h61};
      send_buffered_path();
      path_buf = '{cup_pkg::BYTE_SLASH, cup_pkg::BYTE_DOT};
      send_buffered_path();
   endtask

   task automatic test_encoding_errors();
      path_buf = '{cup_pkg::BYTE_SLASH, cup_pkg::BYTE_NUL};
      send_buffered_path();
      path_buf = '{cup_pkg::BYTE_SLASH, 8'hFF};
      send_buffered_path();
      path_buf = '{cup_pkg::BYTE_SLASH, 8'hC3};
      send_buffered_path();
      path_buf = '{cup_pkg::BYTE_SLASH, 8'hC3, cup_pkg::BYTE_NUL};
      send_buffered_path();
      set_path_rules(1'b0);
      path_buf = '{cup_pkg::BYTE_NUL};
      send_buffered_path();
      path_buf = '{cup_pkg::CONT_LO};
      send_buffered_path();
   endtask

   task automatic test_mode_switch_mid_path();
      set_path_rules(1'b1);
      send_byte(cup_pkg::BYTE_SLASH, 1'b0);
      set_path_rules(1'b0);
      send_byte(cup_pkg::LEAD3_LO, 1'b0);
      send_byte(cup_pkg::CONT_LO, 1'b1);
      send_byte(cup_pkg::BYTE_SLASH, 1'b0);
      send_byte(8'h61, 1'b0);
      set_path_rules(1'b1);
      send_byte(cup_pkg::BYTE_BACKSLASH, 1'b1);
   endtask

   task automatic test_random_paths(input logic rules, input int budget, input bit quiet);
      int start;
      set_path_rules(rules);
      steady_flow = quiet;
      start = bytes_sent;
      while (bytes_sent - start < budget) begin
         build_random_path();
         send_buffered_path();
      end
      steady_flow = 1'b0;
   endtask

   always @(negedge clock) begin
      rsp_bus.ready <= steady_flow || ($urandom_range(99) >= 30);
   end

   always @(posedge clock) begin
      verdict_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_verdicts.size() == 0) begin
            $error("verdict with none expected: path_ok %0d error_code %0d",
                   rsp_bus.path_ok, rsp_bus.error_code);
            mismatches++;
         end else begin
            want = expected_verdicts.pop_front();
            verdicts_checked++;
            if (rsp_bus.path_ok !== want.ok) begin
               $error("path_ok: expected %0d, actual %0d", want.ok, rsp_bus.path_ok);
               mismatches++;
            end
            if (rsp_bus.error_code !== want.code) begin
               $error("error_code: expected %0d, actual %0d", want.code, rsp_bus.error_code);
               mismatches++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)
          || (csr_bus.valid && csr_bus.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
         $display("Timeout: no transaction for %0d cycles", STALL_LIMIT);
         $display("Mismatches found");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      req_bus.valid = 1'b0;
      req_bus.path_byte = 8'h00;
      req_bus.last_byte = 1'b0;
      rsp_bus.ready = 1'b0;
      csr_bus.valid = 1'b0;
      csr_bus.check_path_rules = 1'b1;
      path_rules_on = 1'b1;
      clear_path_state();
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_path_rule_errors();
      test_encoding_errors();
      test_mode_switch_mid_path();
      test_random_paths(1'b1, 700, 1'b0);
      test_random_paths(1'b0, 450, 1'b0);
      test_random_paths(1'b1, 400, 1'b1);
      test_random_paths(1'b0, 200, 1'b0);

      drain_verdicts();
      repeat (8) @(posedge clock);
      $display("Checked %0d verdicts over %0d path bytes, in path and UTF-8 only modes,",
               verdicts_checked, bytes_sent);
      $display("with random stalls on both channels and mode changes between and within paths.");
      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

### canonical_utf8_path_checker.f
rtl/core/cup_pkg.sv
rtl/core/cup_ifs.sv
rtl/core/cup_track.sv
rtl/core/canonical_utf8_path_checker.sv
tb/canonical_utf8_path_checker_tb.sv
